>>> hw/rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition");
`endif

>>> hw/rtl/ccfd_pkg.sv
`default_nettype none
package ccfd_pkg;
  localparam int unsigned HeaderBytes = 40;
  localparam logic [31:0] CrcPoly = 32'h82F63B78;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;
  localparam logic [31:0] Magic = 32'h464B5650;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindAccept = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  localparam logic [1:0] RegMaxKey = 2'd0;
  localparam logic [1:0] RegMaxVal = 2'd1;
  localparam logic [1:0] RegMaxFrame = 2'd2;

  typedef enum logic [3:0] {
    ErrNone = 4'd0, ErrMagic = 4'd1, ErrVersion = 4'd2, ErrHdrSize = 4'd3,
    ErrHdrCrc = 4'd4, ErrFlags = 4'd5, ErrReserved = 4'd6, ErrZeroId = 4'd7,
    ErrKind = 4'd8, ErrOpcode = 4'd9, ErrStatus = 4'd10, ErrKeyLen = 4'd11,
    ErrValLen = 4'd12, ErrFrameSize = 4'd13, ErrPayCrc = 4'd14, ErrFailed = 4'd15
  } err_e;

  // One entry of the queue between front and back: up to two results.
  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay_byte;
    logic       pay_val;
    logic       has_end;
    logic       end_err;
    err_e       err;
    logic [1:0] fkind;
    logic [3:0] opcode;
    logic [2:0] status;
    logic [63:0] req_id;
    logic [31:0] klen;
    logic [31:0] vlen;
  } cmd_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/crc32c_checked_frame_deframer_top.sv
// Frame deframer with CRC-32C checks. One byte per cycle is accepted while the
// result queue has room; the front parser updates the byte counter and a
// byte-wide CRC-32C as each byte is accepted. Results pass through a two-entry
// queue; a final payload byte produces two result transfers (byte, then
// accept/error). After any error every byte yields a parser-failed error until
// reset. Config writes are taken at any time and should occur only while idle.
`default_nettype none
module crc32c_checked_frame_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [33:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       payload_byte_o,
  output logic             in_value_o,
  output logic [1:0]       frame_kind_o,
  output logic [3:0]       opcode_o,
  output logic [2:0]       status_code_o,
  output logic [63:0]      request_id_o,
  output logic [31:0]      key_length_o,
  output logic [31:0]      value_length_o,
  output logic [3:0]       error_code_o,
  output logic             last_o
);
  logic [31:0] mk_q, mv_q;
  logic [33:0] mf_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mk_q <= 32'd1024; mv_q <= 32'd1048576; mf_q <= 34'd1049640;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ccfd_pkg::RegMaxKey: mk_q <= cfg_data_i[31:0];
        ccfd_pkg::RegMaxVal: mv_q <= cfg_data_i[31:0];
        ccfd_pkg::RegMaxFrame: mf_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic c_valid, q_ready, q_valid, q_pop;
  ccfd_pkg::cmd_t c_cmd, q_cmd;

  ccfd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i,
    .max_key_i(mk_q), .max_val_i(mv_q), .max_frame_i(mf_q),
    .cmd_valid_o(c_valid), .cmd_ready_i(q_ready), .cmd_o(c_cmd)
  );
  ccfd_queue u_queue (
    .clk_i, .rst_ni, .push_i(c_valid), .ready_o(q_ready), .d_i(c_cmd),
    .valid_o(q_valid), .pop_i(q_pop), .q_o(q_cmd)
  );
  ccfd_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_pop_o(q_pop), .cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .result_kind_o, .payload_byte_o, .in_value_o,
    .frame_kind_o, .opcode_o, .status_code_o, .request_id_o, .key_length_o,
    .value_length_o, .error_code_o, .last_o
  );
endmodule
`default_nettype wire

>>> hw/rtl/ccfd_front.sv
`default_nettype none
`include "assert_macros.svh"
module ccfd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic [31:0]   max_key_i,
  input  wire logic [31:0]   max_val_i,
  input  wire logic [33:0]   max_frame_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output ccfd_pkg::cmd_t     cmd_o
);
  logic [7:0]  hdr_q [ccfd_pkg::HeaderBytes];
  logic [33:0] cnt_q, cnt_d;
  logic [33:0] total_q, total_d;
  logic [31:0] hcrc_q, hcrc_d, pcrc_q, pcrc_d;
  logic        inpay_q, inpay_d, failed_q, failed_d;
  logic        push;
  ccfd_pkg::cmd_t cmd;
  logic        emit;

  assign in_ready_o = cmd_ready_i;
  assign push = in_valid_i && in_ready_o;

  logic [31:0] f_magic, f_hcrc, f_pcrc, f_klen, f_vlen;
  logic [15:0] f_ver, f_hsz, f_st, f_flg, f_rsv;
  logic [63:0] f_id;
  logic [7:0]  f_kind, f_op;
  logic [33:0] f_tot;
  logic [31:0] last_word;
  // last header byte arrives this cycle; build fields with it
  always_comb begin
    last_word = {hdr_q[36], hdr_q[37], hdr_q[38], data_byte_i};
    f_magic = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]};
    f_ver = {hdr_q[4], hdr_q[5]};
    f_hsz = {hdr_q[6], hdr_q[7]};
    f_kind = hdr_q[8];
    f_op = hdr_q[9];
    f_st = {hdr_q[10], hdr_q[11]};
    f_flg = {hdr_q[12], hdr_q[13]};
    f_rsv = {hdr_q[14], hdr_q[15]};
    f_id = {hdr_q[16], hdr_q[17], hdr_q[18], hdr_q[19],
            hdr_q[20], hdr_q[21], hdr_q[22], hdr_q[23]};
    f_klen = {hdr_q[24], hdr_q[25], hdr_q[26], hdr_q[27]};
    f_vlen = {hdr_q[28], hdr_q[29], hdr_q[30], hdr_q[31]};
    f_hcrc = {hdr_q[32], hdr_q[33], hdr_q[34], hdr_q[35]};
    f_pcrc = last_word;
    f_tot = 34'(ccfd_pkg::HeaderBytes) + {2'b0, f_klen} + {2'b0, f_vlen};
  end

  logic [31:0] hdr_klen;
  assign hdr_klen = {hdr_q[24], hdr_q[25], hdr_q[26], hdr_q[27]};
  logic [31:0] stored_pcrc;
  assign stored_pcrc = {hdr_q[36], hdr_q[37], hdr_q[38], hdr_q[39]};

  always_comb begin
    ccfd_pkg::err_e e;
    logic [31:0] pc_new;
    cnt_d = cnt_q; total_d = total_q; hcrc_d = hcrc_q; pcrc_d = pcrc_q;
    inpay_d = inpay_q; failed_d = failed_q;
    cmd = '0; emit = 1'b0; e = ccfd_pkg::ErrNone;
    pc_new = ccfd_pkg::crc_byte(pcrc_q, data_byte_i);
    if (failed_q) begin
      emit = 1'b1; cmd.has_end = 1'b1; cmd.end_err = 1'b1; cmd.err = ccfd_pkg::ErrFailed;
    end else if (!inpay_q) begin
      if (cnt_q < 34'd32) hcrc_d = ccfd_pkg::crc_byte(hcrc_q, data_byte_i);
      cnt_d = cnt_q + 34'd1;
      if (cnt_q == 34'(ccfd_pkg::HeaderBytes - 1)) begin
        if (f_magic != ccfd_pkg::Magic) e = ccfd_pkg::ErrMagic;
        else if (f_ver != 16'd1) e = ccfd_pkg::ErrVersion;
        else if (f_hsz != 16'(ccfd_pkg::HeaderBytes)) e = ccfd_pkg::ErrHdrSize;
        else if (f_hcrc != (hcrc_q ^ ccfd_pkg::CrcInit)) e = ccfd_pkg::ErrHdrCrc;
        else if (f_flg != 16'd0) e = ccfd_pkg::ErrFlags;
        else if (f_rsv != 16'd0) e = ccfd_pkg::ErrReserved;
        else if (f_id == 64'd0) e = ccfd_pkg::ErrZeroId;
        else if (f_kind != 8'd1 && f_kind != 8'd2) e = ccfd_pkg::ErrKind;
        else if (f_op < 8'd1 || f_op > 8'd8) e = ccfd_pkg::ErrOpcode;
        else if (f_st > 16'd6) e = ccfd_pkg::ErrStatus;
        else if (f_klen > max_key_i) e = ccfd_pkg::ErrKeyLen;
        else if (f_vlen > max_val_i) e = ccfd_pkg::ErrValLen;
        else if (f_tot > max_frame_i) e = ccfd_pkg::ErrFrameSize;
        if (e != ccfd_pkg::ErrNone) begin
          emit = 1'b1; cmd.has_end = 1'b1; cmd.end_err = 1'b1; cmd.err = e;
          failed_d = 1'b1;
        end else if (f_tot == 34'(ccfd_pkg::HeaderBytes)) begin
          emit = 1'b1; cmd.has_end = 1'b1;
          cnt_d = '0; hcrc_d = ccfd_pkg::CrcInit;
          if (f_pcrc != 32'd0) begin
            cmd.end_err = 1'b1; cmd.err = ccfd_pkg::ErrPayCrc; failed_d = 1'b1;
          end
        end else begin
          inpay_d = 1'b1; total_d = f_tot; pcrc_d = ccfd_pkg::CrcInit;
        end
        cmd.fkind = f_kind[1:0]; cmd.opcode = f_op[3:0]; cmd.status = f_st[2:0];
        cmd.req_id = f_id; cmd.klen = f_klen; cmd.vlen = f_vlen;
      end
    end else begin
      emit = 1'b1;
      cmd.has_pay = 1'b1; cmd.pay_byte = data_byte_i;
      cmd.pay_val = (cnt_q - 34'(ccfd_pkg::HeaderBytes)) >= {2'b0, hdr_klen};
      pcrc_d = pc_new;
      cnt_d = cnt_q + 34'd1;
      if (cnt_d >= total_q) begin
        cmd.has_end = 1'b1;
        cmd.fkind = hdr_q[8][1:0]; cmd.opcode = hdr_q[9][3:0];
        cmd.status = hdr_q[11][2:0];
        cmd.req_id = {hdr_q[16], hdr_q[17], hdr_q[18], hdr_q[19],
                      hdr_q[20], hdr_q[21], hdr_q[22], hdr_q[23]};
        cmd.klen = hdr_klen;
        cmd.vlen = {hdr_q[28], hdr_q[29], hdr_q[30], hdr_q[31]};
        if ((pc_new ^ ccfd_pkg::CrcInit) != stored_pcrc) begin
          cmd.end_err = 1'b1; cmd.err = ccfd_pkg::ErrPayCrc; failed_d = 1'b1;
        end
        cnt_d = '0; total_d = 34'(ccfd_pkg::HeaderBytes);
        hcrc_d = ccfd_pkg::CrcInit; pcrc_d = ccfd_pkg::CrcInit; inpay_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !failed_q && !inpay_q) begin
      hdr_q[cnt_q[5:0]] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; total_q <= 34'(ccfd_pkg::HeaderBytes);
      hcrc_q <= ccfd_pkg::CrcInit; pcrc_q <= ccfd_pkg::CrcInit;
      inpay_q <= 1'b0; failed_q <= 1'b0;
    end else if (push) begin
      cnt_q <= cnt_d; total_q <= total_d; hcrc_q <= hcrc_d; pcrc_q <= pcrc_d;
      inpay_q <= inpay_d; failed_q <= failed_d;
    end
  end

  assign cmd_valid_o = push && emit;
  assign cmd_o = cmd;

  `ASSERT_NEVER(a_hdr_in_range, !failed_q && !inpay_q && cnt_q >= 34'(ccfd_pkg::HeaderBytes))
  `ASSERT_CLK(a_fail_sticky, $past(failed_q) |-> failed_q)
  `ASSERT_NEVER(a_pay_after_fail, cmd_valid_o && failed_q && cmd_o.has_pay)
endmodule
`default_nettype wire

>>> hw/rtl/ccfd_queue.sv
`default_nettype none
`include "assert_macros.svh"
module ccfd_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            ready_o,
  input  wire ccfd_pkg::cmd_t d_i,
  output logic            valid_o,
  input  wire logic       pop_i,
  output ccfd_pkg::cmd_t  q_o
);
  ccfd_pkg::cmd_t mem_q [2];
  logic rp_q, wp_q;
  logic [1:0] n_q;
  assign ready_o = n_q != 2'd2;
  assign valid_o = n_q != 2'd0;
  assign q_o = mem_q[rp_q];
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= d_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= 1'b0; wp_q <= 1'b0; n_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      n_q <= n_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
  `ASSERT_NEVER(a_over, push_i && n_q == 2'd2)
  `ASSERT_NEVER(a_under, pop_i && n_q == 2'd0)
endmodule
`default_nettype wire

>>> hw/rtl/ccfd_back.sv
`default_nettype none
`include "assert_macros.svh"
module ccfd_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  output logic            cmd_pop_o,
  input  wire ccfd_pkg::cmd_t cmd_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      result_kind_o,
  output logic [7:0]      payload_byte_o,
  output logic            in_value_o,
  output logic [1:0]      frame_kind_o,
  output logic [3:0]      opcode_o,
  output logic [2:0]      status_code_o,
  output logic [63:0]     request_id_o,
  output logic [31:0]     key_length_o,
  output logic [31:0]     value_length_o,
  output logic [3:0]      error_code_o,
  output logic            last_o
);
  logic pay_done_q;
  logic doing_pay;
  assign doing_pay = cmd_i.has_pay && !pay_done_q;
  assign out_valid_o = cmd_valid_i;
  assign cmd_pop_o = cmd_valid_i && out_ready_i && (!doing_pay || !cmd_i.has_end);

  always_comb begin
    result_kind_o = ccfd_pkg::KindPayload; payload_byte_o = '0; in_value_o = 1'b0;
    frame_kind_o = '0; opcode_o = '0; status_code_o = '0; request_id_o = '0;
    key_length_o = '0; value_length_o = '0; error_code_o = '0; last_o = 1'b1;
    if (doing_pay) begin
      payload_byte_o = cmd_i.pay_byte; in_value_o = cmd_i.pay_val;
      last_o = !cmd_i.has_end;
    end else if (cmd_i.end_err) begin
      result_kind_o = ccfd_pkg::KindError; error_code_o = cmd_i.err;
    end else begin
      result_kind_o = ccfd_pkg::KindAccept; frame_kind_o = cmd_i.fkind;
      opcode_o = cmd_i.opcode; status_code_o = cmd_i.status;
      request_id_o = cmd_i.req_id; key_length_o = cmd_i.klen;
      value_length_o = cmd_i.vlen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pay_done_q <= 1'b0;
    else if (cmd_pop_o) pay_done_q <= 1'b0;
    else if (cmd_valid_i && out_ready_i && doing_pay) pay_done_q <= 1'b1;
  end

  `ASSERT_CLK(a_split, pay_done_q |-> cmd_valid_i && cmd_i.has_end)
endmodule
`default_nettype wire

>>> test/crc32c_checked_frame_deframer_top_tb.sv
`default_nettype none
module crc32c_checked_frame_deframer_top_tb;
  import ccfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic        inval;
    logic [1:0]  fkind;
    logic [3:0]  op;
    logic [2:0]  st;
    logic [63:0] rid;
    logic [31:0] klen;
    logic [31:0] vlen;
    err_e        err;
    logic        last;
  } result_t;

  typedef struct {
    logic [31:0] klen;
    logic [31:0] vlen;
    logic [1:0]  fkind;
    logic [3:0]  op;
    logic [2:0]  st;
    logic [63:0] rid;
    logic [1:0]  want_end;
  } frame_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [33:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  payload_byte_o;
  logic        in_value_o;
  logic [1:0]  frame_kind_o;
  logic [3:0]  opcode_o;
  logic [2:0]  status_code_o;
  logic [63:0] request_id_o;
  logic [31:0] key_length_o;
  logic [31:0] value_length_o;
  logic [3:0]  error_code_o;
  logic        last_o;

  crc32c_checked_frame_deframer_top dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] lim_key = 32'd1024;
  logic [31:0] lim_val = 32'd1048576;
  logic [33:0] lim_frame = 34'd1049640;
  logic [7:0]  hstore [HeaderBytes];
  logic [33:0] rx_count = '0;
  logic [33:0] frame_len = 34'd40;
  logic [31:0] hdr_crc = CrcInit;
  logic [31:0] pay_crc = CrcInit;
  logic        in_pay = 1'b0;
  logic        sticky_fail = 1'b0;

  result_t     expected_q[$];
  int          mismatches = 0;
  int          bytes_sent = 0;

  function automatic void add_expected(result_t r);
    expected_q = {expected_q, r};
  endfunction

  function automatic logic [31:0] crc32c_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  function automatic logic [63:0] hfield(int off, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v = (v << 8) | hstore[(off + i) % HeaderBytes];
    return v;
  endfunction

  function automatic err_e header_verdict();
    logic [33:0] total;
    logic [63:0] t;
    if (hfield(0, 4) != Magic) return ErrMagic;
    if (hfield(4, 2) != 1) return ErrVersion;
    if (hfield(6, 2) != HeaderBytes) return ErrHdrSize;
    if (hfield(32, 4) != (hdr_crc ^ CrcInit)) return ErrHdrCrc;
    if (hfield(12, 2) != 0) return ErrFlags;
    if (hfield(14, 2) != 0) return ErrReserved;
    if (hfield(16, 8) == 0) return ErrZeroId;
    t = hfield(8, 1);
    if (t != 1 && t != 2) return ErrKind;
    t = hfield(9, 1);
    if (t < 1 || t > 8) return ErrOpcode;
    if (hfield(10, 2) > 6) return ErrStatus;
    if (hfield(24, 4) > lim_key) return ErrKeyLen;
    if (hfield(28, 4) > lim_val) return ErrValLen;
    total = 34'(HeaderBytes) + 34'(hfield(24, 4)) + 34'(hfield(28, 4));
    if (total > lim_frame) return ErrFrameSize;
    frame_len = total;
    return ErrNone;
  endfunction

  function automatic result_t error_result(err_e code);
    result_t r;
    r = '0;
    r.kind = KindError;
    r.err = code;
    r.last = 1'b1;
    sticky_fail = 1'b1;
    return r;
  endfunction

  function automatic result_t frame_end();
    result_t r;
    r = '0;
    if ((pay_crc ^ CrcInit) != hfield(36, 4)) begin
      r = error_result(ErrPayCrc);
    end else begin
      r.kind = KindAccept;
      r.fkind = 2'(hfield(8, 1));
      r.op = 4'(hfield(9, 1));
      r.st = 3'(hfield(10, 2));
      r.rid = hfield(16, 8);
      r.klen = 32'(hfield(24, 4));
      r.vlen = 32'(hfield(28, 4));
      r.last = 1'b1;
    end
    rx_count = '0;
    frame_len = 34'd40;
    hdr_crc = CrcInit;
    pay_crc = CrcInit;
    in_pay = 1'b0;
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    result_t r;
    err_e code;
    r = '0;
    if (sticky_fail) begin
      add_expected(error_result(ErrFailed));
    end else if (!in_pay) begin
      if (rx_count < 32) hdr_crc = crc32c_step(hdr_crc, b);
      hstore[rx_count % HeaderBytes] = b;
      rx_count = rx_count + 34'd1;
      if (rx_count >= HeaderBytes) begin
        code = header_verdict();
        if (code != ErrNone) begin
          add_expected(error_result(code));
        end else begin
          in_pay = 1'b1;
          pay_crc = CrcInit;
          if (rx_count >= frame_len) add_expected(frame_end());
        end
      end
    end else begin
      r.kind = KindPayload;
      r.pbyte = b;
      r.inval = ((rx_count - HeaderBytes) >= hfield(24, 4));
      pay_crc = crc32c_step(pay_crc, b);
      rx_count = rx_count + 34'd1;
      r.last = !(rx_count >= frame_len);
      add_expected(r);
      if (rx_count >= frame_len) add_expected(frame_end());
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b);
    bytes_sent++;
  endtask

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [33:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegMaxKey: lim_key = data[31:0];
      RegMaxVal: lim_val = data[31:0];
      RegMaxFrame: lim_frame = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // broken selects a header or payload fault by its error code, ErrNone for a good frame
  task automatic send_frame(input frame_row_t f, input err_e broken);
    logic [7:0]  h [HeaderBytes];
    logic [7:0]  pay [$];
    logic [31:0] c;
    logic [63:0] rid;
    logic [31:0] kl, vl;
    rid = (broken == ErrZeroId) ? 64'd0 : f.rid;
    kl = f.klen;
    vl = f.vlen;
    pay = {};
    c = CrcInit;
    for (int i = 0; i < kl + vl; i++) begin
      pay = {pay, 8'($urandom)};
      c = crc32c_step(c, pay[i]);
    end
    c = c ^ CrcInit;
    if (broken == ErrPayCrc) c = c ^ (32'd1 << $urandom_range(0, 31));
    {h[0], h[1], h[2], h[3]} = Magic;
    if (broken == ErrMagic) h[$urandom_range(0, 3)] ^= 8'h01;
    {h[4], h[5]} = (broken == ErrVersion) ? 16'd2 : 16'd1;
    {h[6], h[7]} = (broken == ErrHdrSize) ? 16'd41 : 16'(HeaderBytes);
    h[8] = (broken == ErrKind) ? 8'($urandom_range(0, 1) * 3) : 8'(f.fkind);
    h[9] = (broken == ErrOpcode) ? 8'($urandom_range(0, 1) ? 0 : 9) : 8'(f.op);
    {h[10], h[11]} = (broken == ErrStatus) ? 16'd7 : 16'(f.st);
    {h[12], h[13]} = (broken == ErrFlags) ? 16'h8000 : 16'd0;
    {h[14], h[15]} = (broken == ErrReserved) ? 16'd1 : 16'd0;
    {h[16], h[17], h[18], h[19], h[20], h[21], h[22], h[23]} = rid;
    {h[24], h[25], h[26], h[27]} = kl;
    {h[28], h[29], h[30], h[31]} = vl;
    {h[36], h[37], h[38], h[39]} = c;
    c = CrcInit;
    for (int i = 0; i < 32; i++) c = crc32c_step(c, h[i]);
    c = c ^ CrcInit;
    if (broken == ErrHdrCrc) c = c ^ 32'h8000_0000;
    {h[32], h[33], h[34], h[35]} = c;
    for (int i = 0; i < HeaderBytes; i++) send_byte(h[i]);
    if (broken == ErrNone || broken == ErrPayCrc)
      foreach (pay[i]) send_byte(pay[i]);
  endtask

  function automatic frame_row_t random_frame();
    frame_row_t f;
    logic [31:0] kmax, vmax;
    kmax = (lim_key < 8) ? lim_key : 8;
    vmax = (lim_val < 8) ? lim_val : 8;
    f.klen = $urandom_range(0, kmax);
    f.vlen = $urandom_range(0, vmax);
    while (34'(HeaderBytes) + f.klen + f.vlen > lim_frame) begin
      if (f.vlen > 0) f.vlen--;
      else f.klen--;
    end
    f.fkind = 2'($urandom_range(1, 2));
    f.op = 4'($urandom_range(1, 8));
    f.st = 3'($urandom_range(0, 6));
    f.rid = {$urandom, $urandom};
    if (f.rid == 0) f.rid = 64'd1;
    f.want_end = KindAccept;
    return f;
  endfunction

  // receiver with random stalls
  initial begin
    result_t got, want;
    int stall;
    forever begin
      stall = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
      got = {result_kind_o, payload_byte_o, in_value_o, frame_kind_o, opcode_o,
             status_code_o, request_id_o, key_length_o, value_length_o,
             err_e'(error_code_o), last_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  frame_row_t directed [] = '{
    '{32'd0, 32'd0, 2'd1, 4'd1, 3'd0, 64'd1, KindAccept},
    '{32'd1, 32'd0, 2'd2, 4'd8, 3'd6, 64'hFFFF_FFFF_FFFF_FFFF, KindAccept},
    '{32'd0, 32'd1, 2'd1, 4'd8, 3'd0, 64'h8000_0000_0000_0000, KindAccept},
    '{32'd3, 32'd4, 2'd2, 4'd1, 3'd6, 64'h0123_4567_89AB_CDEF, KindAccept},
    '{32'd16, 32'd16, 2'd1, 4'd5, 3'd3, 64'hFEDC_BA98_7654_3210, KindAccept}
  };

  logic [33:0] settings [5][3] = '{
    '{34'd0, 34'd0, 34'd40},
    '{34'hFFFF_FFFF, 34'hFFFF_FFFF, 34'h3_FFFF_FFFF},
    '{34'd3, 34'd5, 34'd45},
    '{34'd1024, 34'd1048576, 34'd1049640},
    '{34'd8, 34'd8, 34'd50}
  };

  initial begin
    err_e broken;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_frame(directed[i], ErrNone);
      if (expected_q.size() == 0 || expected_q[$].kind != directed[i].want_end) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d: end kind not %0d", i,
                                       directed[i].want_end);
      end
    end
    drain();
    write_reg(RegUnused, 34'h0_0000_0005);
    cfg_valid_i <= 1'b0;
    for (int s = 0; s < 5; s++) begin
      drain();
      write_reg(RegMaxKey, {2'($urandom), 32'(settings[s][0])});
      write_reg(RegMaxVal, {2'($urandom), 32'(settings[s][1])});
      write_reg(RegMaxFrame, settings[s][2]);
      cfg_valid_i <= 1'b0;
      for (int n = 0; n < 60; ) begin
        int before_cnt;
        before_cnt = bytes_sent;
        send_frame(random_frame(), ErrNone);
        n += bytes_sent - before_cnt;
      end
    end
    drain();
    broken = err_e'($urandom_range(ErrMagic, ErrPayCrc));
    begin
      frame_row_t f;
      f = random_frame();
      if (broken == ErrKeyLen) f.klen = lim_key + 1;
      if (broken == ErrValLen) f.vlen = lim_val + 1;
      if (broken == ErrFrameSize) begin
        f.klen = 8;
        f.vlen = 8;
      end
      send_frame(f, broken);
    end
    repeat (40) send_byte(8'($urandom));
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
